### rtl/core/index_bit_packer_sub_blocks_core_macros.svh
// Assertion macros shared by the checker of the index bit packer core.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef INDEX_BIT_PACKER_SUB_BLOCKS_CORE_MACROS_SVH
`define INDEX_BIT_PACKER_SUB_BLOCKS_CORE_MACROS_SVH

// Same-cycle implication.
`define IBP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ibp assertion failed");

// Next-cycle implication.
`define IBP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ibp assertion failed");

`endif

### rtl/core/ibp_pkg.sv
// Package of the index bit packer core: payload types, command codes and constants.
// Used by every module of the core; depends on nothing.
package ibp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int MAX_RESULTS = 3;
   localparam logic [8:0] PALETTE_RESET = 9'd256;
   localparam logic [7:0] MAX_BLOCK = 8'd255;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_END = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] pixel_index;
   } req_type;

   typedef struct packed {
      logic [31:0] byte_offset;
      logic [7:0] byte_value;
      logic is_patch;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type [MAX_RESULTS-1:0] items;
   } bundle_type;

   function automatic logic [3:0] key_width(input logic [8:0] palette_size);
      logic [3:0] w;
      w = 4'd0;
      for (int i = 1; i < 9; i++) begin
         if (palette_size[i]) begin
            w = 4'(i);
         end
      end
      return w;
   endfunction

   localparam logic [3:0] KEY_WIDTH_RESET = key_width(PALETTE_RESET);

endpackage

### rtl/core/ibp_in_stage.sv
// Input register of the index bit packer core.
// Holds one request transaction until the packer takes it; uses ibp_pkg.
module ibp_in_stage (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ibp_pkg::req_type req_data,
   input  logic advance,
   output logic item_valid,
   output ibp_pkg::req_type item_data
);

   logic valid_ff, valid_in;
   ibp_pkg::req_type data_ff;

   assign req_ready = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item_data = data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

### rtl/core/ibp_packer.sv
// Packing and framing logic of the index bit packer core.
// Turns one command into a bundle of up to three results; uses ibp_pkg.
module ibp_packer #(
   parameter int OFFSET_BITS = ibp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  ibp_pkg::req_type item_data,
   input  logic [3:0] key_width,
   output ibp_pkg::bundle_type bundle
);

   logic [7:0] pending_ff, pending_in;
   logic [2:0] fill_ff, fill_in;
   logic [7:0] count_ff, count_in;
   logic [OFFSET_BITS-1:0] slot_ff, slot_in;
   logic [OFFSET_BITS-1:0] wp_ff, wp_in;

   logic [15:0] key_wide, carry_wide;
   logic [7:0] key, merged, count_next, count_end;
   logic [3:0] sum;
   logic flush;
   logic [OFFSET_BITS-1:0] wp_plus1, wp_plus2, end_pos;

   function automatic logic [31:0] to_off(input logic [OFFSET_BITS-1:0] pos);
      logic [OFFSET_BITS+31:0] wide;
      wide = {32'd0, pos};
      return wide[31:0];
   endfunction

   function automatic ibp_pkg::rsp_type make_rsp(input logic [OFFSET_BITS-1:0] pos,
                                                 input logic [7:0] value,
                                                 input logic patch,
                                                 input logic fin);
      ibp_pkg::rsp_type r;
      r.byte_offset = to_off(pos);
      r.byte_value = value;
      r.is_patch = patch;
      r.last = fin;
      return r;
   endfunction

   always_comb begin
      key_wide = {8'd0, item_data.pixel_index} << (4'd8 - key_width);
      key = key_wide[7:0];
      merged = pending_ff | (key >> fill_ff);
      sum = {1'b0, fill_ff} + key_width;
      carry_wide = {8'd0, key} << (4'd8 - {1'b0, fill_ff});
      count_next = count_ff + 8'd1;
      flush = (fill_ff != 3'd0);
      count_end = flush ? count_next : count_ff;
      wp_plus1 = wp_ff + OFFSET_BITS'(1);
      wp_plus2 = wp_ff + OFFSET_BITS'(2);
      end_pos = flush ? wp_plus1 : wp_ff;
   end

   always_comb begin
      bundle = '0;
      pending_in = pending_ff;
      fill_in = fill_ff;
      count_in = count_ff;
      slot_in = slot_ff;
      wp_in = wp_ff;
      case (item_data.cmd)
         ibp_pkg::CMD_START: begin
            bundle.count = 2'd1;
            bundle.items[0] = make_rsp('0, {4'd0, key_width}, 1'b0, 1'b1);
            wp_in = OFFSET_BITS'(2);
            slot_in = OFFSET_BITS'(1);
            pending_in = 8'd0;
            fill_in = 3'd0;
            count_in = 8'd0;
         end
         ibp_pkg::CMD_PIXEL: begin
            fill_in = sum[2:0];
            if (sum > 4'd7) begin
               pending_in = carry_wide[7:0];
               if (count_next == ibp_pkg::MAX_BLOCK) begin
                  bundle.count = 2'd2;
                  bundle.items[0] = make_rsp(wp_ff, merged, 1'b0, 1'b0);
                  bundle.items[1] = make_rsp(slot_ff, ibp_pkg::MAX_BLOCK, 1'b1, 1'b1);
                  count_in = 8'd0;
                  slot_in = wp_plus1;
                  wp_in = wp_plus2;
               end else begin
                  bundle.count = 2'd1;
                  bundle.items[0] = make_rsp(wp_ff, merged, 1'b0, 1'b1);
                  count_in = count_next;
                  wp_in = wp_plus1;
               end
            end else begin
               pending_in = merged;
            end
         end
         ibp_pkg::CMD_END: begin
            pending_in = 8'd0;
            fill_in = 3'd0;
            count_in = 8'd0;
            if (flush) begin
               bundle.items[0] = make_rsp(wp_ff, pending_ff, 1'b0, 1'b0);
               if (count_end != 8'd0) begin
                  bundle.count = 2'd3;
                  bundle.items[1] = make_rsp(slot_ff, count_end, 1'b1, 1'b0);
                  bundle.items[2] = make_rsp(end_pos, 8'd0, 1'b0, 1'b1);
                  wp_in = end_pos + OFFSET_BITS'(1);
               end else begin
                  bundle.count = 2'd2;
                  bundle.items[1] = make_rsp(slot_ff, 8'd0, 1'b1, 1'b1);
                  wp_in = end_pos;
               end
            end else begin
               if (count_end != 8'd0) begin
                  bundle.count = 2'd2;
                  bundle.items[0] = make_rsp(slot_ff, count_end, 1'b1, 1'b0);
                  bundle.items[1] = make_rsp(end_pos, 8'd0, 1'b0, 1'b1);
                  wp_in = end_pos + OFFSET_BITS'(1);
               end else begin
                  bundle.count = 2'd1;
                  bundle.items[0] = make_rsp(slot_ff, 8'd0, 1'b1, 1'b1);
                  wp_in = end_pos;
               end
            end
         end
         default: begin
            bundle.count = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 8'd0;
         fill_ff <= 3'd0;
         count_ff <= 8'd0;
         slot_ff <= '0;
         wp_ff <= '0;
      end else if (advance) begin
         pending_ff <= pending_in;
         fill_ff <= fill_in;
         count_ff <= count_in;
         slot_ff <= slot_in;
         wp_ff <= wp_in;
      end
   end

endmodule

### rtl/core/ibp_rsp_seq.sv
// Result register of the index bit packer core.
// Holds one bundle and hands its results out one transaction at a time; uses ibp_pkg.
module ibp_rsp_seq (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  ibp_pkg::bundle_type bundle,
   output logic free,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ibp_pkg::rsp_type rsp_data
);

   logic [1:0] count_ff, count_in;
   ibp_pkg::rsp_type [ibp_pkg::MAX_RESULTS-1:0] items_ff, items_in;
   logic pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data = items_ff[0];
   assign pop = rsp_valid && rsp_ready;
   assign free = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_comb begin
      count_in = count_ff;
      items_in = items_ff;
      if (load) begin
         count_in = bundle.count;
         items_in = bundle.items;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         for (int i = 0; i < ibp_pkg::MAX_RESULTS - 1; i++) begin
            items_in[i] = items_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
   end

endmodule

### rtl/core/index_bit_packer_sub_blocks_core.sv
// Top level of the index bit packer core with length-prefixed sub-blocks.
// Instantiates ibp_in_stage, ibp_packer and ibp_rsp_seq; uses ibp_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    ibp_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    ibp_pkg::rsp_type
//   csr      in         csr_write_enable       palette size, 9 bits
//
// A command goes from the input register through the packer into the result
// register, which drives the rsp port. Each result takes one cycle on the rsp
// port while rsp_ready is high; a command has up to three results, and some
// commands, such as a pixel that completes no byte, have none.
// Reset is synchronous; it clears the packing state and empties both registers.
// A stalled rsp port holds the result and stops the req port once the input
// register is full.
module index_bit_packer_sub_blocks_core #(
   parameter int OFFSET_BITS = ibp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ibp_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ibp_pkg::rsp_type rsp_data,
   input  logic csr_write_enable,
   input  logic [8:0] csr_write_data
);

   logic [3:0] key_width_ff;
   logic item_valid, free, advance;
   ibp_pkg::req_type item_data;
   ibp_pkg::bundle_type bundle;

   assign advance = item_valid && free;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_width_ff <= ibp_pkg::KEY_WIDTH_RESET;
      end else if (csr_write_enable) begin
         key_width_ff <= ibp_pkg::key_width(csr_write_data);
      end
   end

   ibp_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .advance(advance),
      .item_valid(item_valid),
      .item_data(item_data)
   );

   ibp_packer #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_packer (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .item_data(item_data),
      .key_width(key_width_ff),
      .bundle(bundle)
   );

   ibp_rsp_seq u_rsp_seq (
      .clock(clock),
      .reset(reset),
      .load(advance),
      .bundle(bundle),
      .free(free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

### rtl/core/ibp_checker.sv
// Port-level checker of the index bit packer core, bound to the top level.
// Uses ibp_pkg and the assertion macros header.
`include "index_bit_packer_sub_blocks_core_macros.svh"

module ibp_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input ibp_pkg::rsp_type rsp_data
);

   `IBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `IBP_ASSERT_NEXT(a_rest_follows, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid)
   `IBP_ASSERT_SAME(a_mid_patch_nonzero, rsp_valid && rsp_data.is_patch && !rsp_data.last, rsp_data.byte_value != 8'd0)
   `IBP_ASSERT_SAME(a_empty_patch_last, rsp_valid && rsp_data.is_patch && (rsp_data.byte_value == 8'd0), rsp_data.last)

endmodule

bind index_bit_packer_sub_blocks_core ibp_checker u_checker (.*);
